### design/bra_pkg.sv
package bra_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int FRAC_BITS  = 32;

    typedef struct packed {
        logic signed [63:0] value_fixed;
        logic [31:0]        denom_limit;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [63:0] numer_out;
        logic [31:0]        denom_out;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

endpackage

### design/bra_div.sv
module bra_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bra_pkg::div_req_t req,
    output bra_pkg::div_rsp_t rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb begin
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.a;
            rem_next  = '0;
            den_next  = req.b;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### design/bra_mul.sv
module bra_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  bra_pkg::mul_req_t req,
    output bra_pkg::mul_rsp_t rsp
);

    // 32x32 partial products, one per cycle
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  opa, opb;
    logic [63:0]  pp_reg;
    logic [127:0] pp_ext;
    logic [1:0]   pp_idx_reg;
    logic         pp_vld_reg;

    always_comb begin
        opa = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        opb = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
        unique case ({pp_idx_reg[1], pp_idx_reg[0]})
            2'b00:   pp_ext = {64'd0, pp_reg};
            2'b11:   pp_ext = {pp_reg, 64'd0};
            default: pp_ext = {32'd0, pp_reg, 32'd0};
        endcase
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = pp_vld_reg ? acc_reg + pp_ext : acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
            pp_vld_reg <= busy_reg && !req.start && (step_reg < 3'd4);
        end
        pp_reg     <= opa * opb;
        pp_idx_reg <= step_reg[1:0];
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

### design/bra_ctrl.sv
module bra_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bra_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bra_pkg::out_item_t m_data,
    output bra_pkg::div_req_t  dreq,
    input  bra_pkg::div_rsp_t  drsp,
    output bra_pkg::mul_req_t  mreq,
    input  bra_pkg::mul_rsp_t  mrsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MA, S_MB, S_UPD, S_TDIV, S_TM1, S_TM2,
        S_LHS, S_RHS, S_DONE, S_OUT
    } state_t;

    localparam logic [63:0] DmMask = {64{1'b1}} >> (64 - bra_pkg::DATA_WIDTH);
    localparam logic [63:0] SgnBit = 64'd1 << (bra_pkg::DATA_WIDTH - 1);
    localparam logic [63:0] OneFix = 64'd1 << bra_pkg::FRAC_BITS;

    state_t      state_reg;
    logic        neg_reg;
    logic [31:0] lim_reg;
    logic [63:0] rt_reg, rb_reg, r_reg, a_reg;
    logic [63:0] h0_reg, k0_reg, h1_reg, k1_reg, h2_reg, k2_reg;
    logic [63:0] t_reg, n2_reg, d2_reg;
    logic [127:0] lhs_reg;
    logic        m_valid_reg;
    bra_pkg::out_item_t m_data_reg;
    logic [63:0] v, mag, num, den;

    always_comb begin
        v   = s_data.value_fixed & DmMask;
        mag = ((~v) + 64'd1) & DmMask;
        if (mag == SgnBit) mag = SgnBit - 64'd1;
        if ((v & SgnBit) == 64'd0) mag = v;
    end

    always_comb begin
        dreq = '0;
        mreq = '0;
        unique case (state_reg)
            S_IDLE: begin
                dreq.a = mag;
                dreq.b = OneFix;
                dreq.start = s_valid && s_data.denom_limit != 32'd0 && mag != 64'd0;
            end
            S_UPD: begin
                if (k2_reg > {32'd0, lim_reg}) begin
                    dreq.a = {32'd0, lim_reg} - k0_reg;
                    dreq.b = k1_reg;
                    dreq.start = k1_reg != 64'd0;
                end else begin
                    dreq.a = rb_reg;
                    dreq.b = r_reg;
                    dreq.start = r_reg != 64'd0;
                end
                mreq.a = a_reg;
                mreq.b = h1_reg;
            end
            S_DIV: begin
                mreq.start = drsp.done;
                mreq.a = drsp.quo;
                mreq.b = h1_reg;
            end
            S_MA: begin
                mreq.start = mrsp.done;
                mreq.a = a_reg;
                mreq.b = k1_reg;
            end
            S_TM1: begin
                mreq.start = mrsp.done;
                mreq.a = t_reg;
                mreq.b = k1_reg;
            end
            S_TM2: begin
                mreq.start = mrsp.done;
                mreq.a = k1_reg;
                mreq.b = rt_reg;
            end
            S_LHS: begin
                // d2 - k0 = t*k1, so k0 + 2*t*k1 = 2*d2 - k0
                mreq.start = mrsp.done;
                mreq.a = k0_reg + {d2_reg[62:0], 1'b0} - {k0_reg[62:0], 1'b0};
                mreq.b = rb_reg;
            end
            S_TDIV: begin
                mreq.start = drsp.done;
                mreq.a = drsp.quo;
                mreq.b = h1_reg;
            end
            default: ;
        endcase
        if (d2_reg != 64'd0 && lhs_reg <= mrsp.prod) begin
            num = n2_reg;
            den = d2_reg;
        end else begin
            num = h1_reg;
            den = k1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        neg_reg <= (v & SgnBit) != 64'd0;
                        lim_reg <= s_data.denom_limit;
                        rt_reg  <= mag;
                        rb_reg  <= OneFix;
                        h0_reg  <= 64'd0; k0_reg <= 64'd1;
                        h1_reg  <= 64'd1; k1_reg <= 64'd0;
                        if (s_data.denom_limit == 32'd0) begin
                            m_data_reg  <= '0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else if (mag == 64'd0) begin
                            m_data_reg  <= '{ok: 1'b1, numer_out: 64'sd0, denom_out: 32'd1};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: if (drsp.done) begin
                    a_reg <= drsp.quo;
                    r_reg <= drsp.rem;
                    state_reg <= S_MA;
                end
                S_MA: if (mrsp.done) begin
                    h2_reg <= mrsp.prod[63:0] + h0_reg;
                    state_reg <= S_MB;
                end
                S_MB: if (mrsp.done) begin
                    k2_reg <= mrsp.prod[63:0] + k0_reg;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (k2_reg > {32'd0, lim_reg}) begin
                        if (k1_reg != 64'd0) state_reg <= S_TDIV;
                        else state_reg <= S_DONE;
                        t_reg <= '0;
                    end else begin
                        h0_reg <= h1_reg; k0_reg <= k1_reg;
                        h1_reg <= h2_reg; k1_reg <= k2_reg;
                        if (r_reg == 64'd0) begin
                            d2_reg <= '0;
                            state_reg <= S_DONE;
                        end else begin
                            rt_reg <= rb_reg;
                            rb_reg <= r_reg;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_TDIV: if (drsp.done) begin
                    t_reg <= drsp.quo;
                    state_reg <= S_TM1;
                end
                S_TM1: if (mrsp.done) begin
                    n2_reg <= h0_reg + mrsp.prod[63:0];
                    state_reg <= S_TM2;
                end
                S_TM2: if (mrsp.done) begin
                    d2_reg <= k0_reg + mrsp.prod[63:0];
                    state_reg <= S_LHS;
                end
                S_LHS: if (mrsp.done) begin
                    lhs_reg <= mrsp.prod;
                    state_reg <= S_RHS;
                end
                S_RHS: if (mrsp.done) begin
                    m_data_reg.ok        <= 1'b1;
                    m_data_reg.numer_out <= neg_reg ? 64'd0 - num : num;
                    m_data_reg.denom_out <= den[31:0];
                    m_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_DONE: begin
                    m_data_reg.ok        <= 1'b1;
                    m_data_reg.numer_out <= neg_reg ? 64'd0 - h1_reg : h1_reg;
                    m_data_reg.denom_out <= k1_reg[31:0];
                    m_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) begin
                    m_valid_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/best_rational_approximation_unit.sv
// Best rational approximation of a signed fixed-point value under a denominator limit,
// by continued fraction expansion. One transfer in, one transfer out; the block is not
// ready while an item is in work. Each partial quotient costs one pass of the shared
// restoring divider plus two multiplies on the shared 32x32 multiplier and one update
// state; the closing semiconvergent test adds one more divider pass and four multiplies.
// An item takes up to about 46 quotients; a zero limit or zero value skips the divider
// and goes straight to the output.
module best_rational_approximation_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bra_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bra_pkg::out_item_t m_data
);

    bra_pkg::div_req_t dreq;
    bra_pkg::div_rsp_t drsp;
    bra_pkg::mul_req_t mreq;
    bra_pkg::mul_rsp_t mrsp;

    bra_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    bra_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    bra_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .dreq(dreq), .drsp(drsp), .mreq(mreq), .mrsp(mrsp)
    );

endmodule
